// ===== rtl/gsp_pkg.sv =====
// Shared types and constants for the geometry string parser.
// Used by gsp_front, gsp_back and geometry_spec_parser; no dependencies.
package gsp_pkg;

  // Default width of the signed result values
  localparam int DEF_VALUE_BITS = 16;

  // Depth of the token queue between front and back
  localparam int TOK_DEPTH = 4;

  // Character codes recognized by the classifier
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_EQ    = 8'h3D;  // '='
  localparam logic [7:0] CH_LX    = 8'h78;  // 'x'
  localparam logic [7:0] CH_UX    = 8'h58;  // 'X'
  localparam logic [7:0] CH_PLUS  = 8'h2B;  // '+'
  localparam logic [7:0] CH_MINUS = 8'h2D;  // '-'
  localparam logic [7:0] CH_D0    = 8'h30;  // '0'
  localparam logic [7:0] CH_D9    = 8'h39;  // '9'

  // Character class carried from front to back
  typedef enum logic [2:0] {
    TK_ZERO,
    TK_DIGIT,
    TK_PLUS,
    TK_MINUS,
    TK_LX,
    TK_UX,
    TK_EQ,
    TK_OTHER
  } tok_class_e;

  // One classified character
  typedef struct packed {
    tok_class_e  cls;
    logic [3:0]  digit;
  } token_t;

  // Bit positions in the found-flags vector
  localparam int FL_X    = 0;
  localparam int FL_Y    = 1;
  localparam int FL_W    = 2;
  localparam int FL_H    = 3;
  localparam int FL_XNEG = 4;
  localparam int FL_YNEG = 5;

endpackage

// ===== rtl/gsp_front.sv =====
// Front end of the geometry string parser: classifies each character and
// queues the tokens for the back end. Depends on gsp_pkg.
module gsp_front import gsp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  output logic       full_o,
  input  logic [7:0] ch_i,
  output logic       tok_valid_o,
  output token_t     tok_o,
  input  logic       tok_pop_i
);

  localparam int PtrW = $clog2(TOK_DEPTH);
  localparam int CntW = $clog2(TOK_DEPTH + 1);

  token_t              tok_buf_q [TOK_DEPTH];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     count_q;
  token_t              tok_in;
  logic                wr_en, rd_en;

  // Classify the incoming character
  always_comb begin
    tok_in.digit = ch_i[3:0];  // low nibble is the digit value for '0'..'9'
    if (ch_i == CH_NUL) begin
      tok_in.cls = TK_ZERO;
    end else if (ch_i >= CH_D0 && ch_i <= CH_D9) begin
      tok_in.cls = TK_DIGIT;
    end else if (ch_i == CH_PLUS) begin
      tok_in.cls = TK_PLUS;
    end else if (ch_i == CH_MINUS) begin
      tok_in.cls = TK_MINUS;
    end else if (ch_i == CH_LX) begin
      tok_in.cls = TK_LX;
    end else if (ch_i == CH_UX) begin
      tok_in.cls = TK_UX;
    end else if (ch_i == CH_EQ) begin
      tok_in.cls = TK_EQ;
    end else begin
      tok_in.cls = TK_OTHER;
    end
  end

  assign full_o      = (count_q == CntW'(TOK_DEPTH));
  assign tok_valid_o = (count_q != '0);
  assign tok_o       = tok_buf_q[rd_ptr_q];
  assign wr_en       = push_i && !full_o;
  assign rd_en       = tok_pop_i && tok_valid_o;

  // Store tokens
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      tok_buf_q[wr_ptr_q] <= tok_in;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (rd_en) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      if (wr_en && !rd_en) begin
        count_q <= count_q + CntW'(1);
      end else if (rd_en && !wr_en) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(TOK_DEPTH))
    else $error("token queue occupancy out of range");

  a_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && !rd_en) |=> (count_q == $past(count_q) + CntW'(1)))
    else $error("token queue did not grow on write");

  a_count_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_en && !wr_en) |=> (count_q == $past(count_q) - CntW'(1)))
    else $error("token queue did not shrink on read");

endmodule

// ===== rtl/gsp_back.sv =====
// Back end of the geometry string parser: runs the parse state machine on
// queued tokens and holds one finished result. Depends on gsp_pkg.
module gsp_back import gsp_pkg::*; #(
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         tok_valid_i,
  input  token_t                       tok_i,
  output logic                         tok_pop_o,
  input  logic                         pop_i,
  output logic                         empty_o,
  output logic                         x_present_o,
  output logic                         y_present_o,
  output logic                         width_present_o,
  output logic                         height_present_o,
  output logic                         x_from_right_o,
  output logic                         y_from_bottom_o,
  output logic signed [VALUE_BITS-1:0] width_value_o,
  output logic signed [VALUE_BITS-1:0] height_value_o,
  output logic signed [VALUE_BITS-1:0] x_value_o,
  output logic signed [VALUE_BITS-1:0] y_value_o
);

  localparam int MagW = VALUE_BITS - 1;
  localparam int AccW = VALUE_BITS + 3;
  localparam logic [AccW-1:0] MagMaxExt = {4'b0, {MagW{1'b1}}};

  // Parse phases
  localparam logic [3:0] PH_START   = 4'd0;
  localparam logic [3:0] PH_WPOS    = 4'd1;
  localparam logic [3:0] PH_W_NUM   = 4'd2;
  localparam logic [3:0] PH_AFTER_W = 4'd3;
  localparam logic [3:0] PH_H_NUM   = 4'd4;
  localparam logic [3:0] PH_AFTER_H = 4'd5;
  localparam logic [3:0] PH_X_NUM   = 4'd6;
  localparam logic [3:0] PH_AFTER_X = 4'd7;
  localparam logic [3:0] PH_Y_NUM   = 4'd8;
  localparam logic [3:0] PH_AFTER_Y = 4'd9;
  localparam logic [3:0] PH_ERROR   = 4'd10;

  // Parse state
  logic [3:0]            phase_q, phase_d;
  logic [MagW-1:0]       mag_q, mag_d;
  logic                  open_q, open_d;
  logic                  inner_neg_q, inner_neg_d;
  logic                  outer_neg_q, outer_neg_d;
  logic [5:0]            flags_q, flags_d;
  logic [VALUE_BITS-1:0] w_q, w_d, h_q, h_d, x_q, x_d, y_q, y_d;

  // Result register
  logic                  out_valid_q, out_valid_d;
  logic [5:0]            out_flags_q;
  logic [VALUE_BITS-1:0] out_w_q, out_h_q, out_x_q, out_y_q;

  // Working values for one token
  logic [3:0]            ph_v;
  logic [MagW-1:0]       mag_v;
  logic                  open_v, inner_v, outer_v, consumed, done;
  logic [5:0]            flags_v;
  logic [VALUE_BITS-1:0] w_v, h_v, x_v, y_v, num_pos, num_neg;
  logic [AccW-1:0]       acc;
  logic                  is_zero, is_sign, is_neg, take;

  assign is_zero = (tok_i.cls == TK_ZERO);
  assign is_neg  = (tok_i.cls == TK_MINUS);
  assign is_sign = (tok_i.cls == TK_PLUS) || is_neg;

  // Stall a terminator only while the result slot is occupied and not being popped
  assign take      = tok_valid_i && !(is_zero && out_valid_q && !pop_i);
  assign tok_pop_o = take;

  // Step the parser by one token
  always_comb begin
    ph_v     = phase_q;
    mag_v    = mag_q;
    open_v   = open_q;
    inner_v  = inner_neg_q;
    outer_v  = outer_neg_q;
    flags_v  = flags_q;
    w_v      = w_q;
    h_v      = h_q;
    x_v      = x_q;
    y_v      = y_q;
    consumed = 1'b0;
    done     = 1'b0;
    acc      = '0;
    num_pos  = '0;
    num_neg  = '0;

    // Skip one leading '='
    if (ph_v == PH_START) begin
      if (is_zero) begin
        done     = 1'b1;
        consumed = 1'b1;
      end else begin
        ph_v = PH_WPOS;
        if (tok_i.cls == TK_EQ) begin
          consumed = 1'b1;
        end
      end
    end

    // Decide whether a width follows
    if (!consumed && ph_v == PH_WPOS) begin
      if (is_sign || tok_i.cls == TK_LX) begin
        ph_v = PH_AFTER_W;
      end else begin
        ph_v = PH_W_NUM;
      end
      mag_v   = '0;
      open_v  = 1'b0;
      inner_v = 1'b0;
    end

    // Accumulate a number or close it
    if (!consumed && (ph_v == PH_W_NUM || ph_v == PH_H_NUM ||
                      ph_v == PH_X_NUM || ph_v == PH_Y_NUM)) begin
      acc     = ({4'b0, mag_v} << 3) + ({4'b0, mag_v} << 1) + {{MagW{1'b0}}, tok_i.digit};
      num_pos = {1'b0, mag_v};
      num_neg = -num_pos;
      if (tok_i.cls == TK_DIGIT) begin
        mag_v    = (acc > MagMaxExt) ? {MagW{1'b1}} : acc[MagW-1:0];
        open_v   = 1'b1;
        consumed = 1'b1;
      end else if (!open_v && is_sign && ph_v != PH_W_NUM) begin
        inner_v  = is_neg;
        open_v   = 1'b1;
        consumed = 1'b1;
      end else if (!open_v) begin
        ph_v     = PH_ERROR;
      end else begin
        case (ph_v)
          PH_W_NUM: begin
            w_v           = num_pos;
            flags_v[FL_W] = 1'b1;
            ph_v          = PH_AFTER_W;
          end
          PH_H_NUM: begin
            h_v           = inner_v ? num_neg : num_pos;
            flags_v[FL_H] = 1'b1;
            ph_v          = PH_AFTER_H;
          end
          PH_X_NUM: begin
            x_v           = (inner_v != outer_v) ? num_neg : num_pos;
            flags_v[FL_X] = 1'b1;
            if (outer_v) begin
              flags_v[FL_XNEG] = 1'b1;
            end
            ph_v          = PH_AFTER_X;
          end
          default: begin
            y_v           = (inner_v != outer_v) ? num_neg : num_pos;
            flags_v[FL_Y] = 1'b1;
            if (outer_v) begin
              flags_v[FL_YNEG] = 1'b1;
            end
            ph_v          = PH_AFTER_Y;
          end
        endcase
      end
    end

    // Handle the separator after a number
    if (!consumed && (ph_v == PH_AFTER_W || ph_v == PH_AFTER_H ||
                      ph_v == PH_AFTER_X || ph_v == PH_AFTER_Y)) begin
      consumed = 1'b1;
      if (is_zero) begin
        done = 1'b1;
      end else if (ph_v == PH_AFTER_W &&
                   (tok_i.cls == TK_LX || tok_i.cls == TK_UX)) begin
        ph_v    = PH_H_NUM;
        mag_v   = '0;
        open_v  = 1'b0;
        inner_v = 1'b0;
      end else if (ph_v != PH_AFTER_Y && is_sign) begin
        ph_v    = (ph_v == PH_AFTER_X) ? PH_Y_NUM : PH_X_NUM;
        outer_v = is_neg;
        mag_v   = '0;
        open_v  = 1'b0;
        inner_v = 1'b0;
      end else begin
        ph_v = PH_ERROR;
      end
    end

    // Drop characters after an error until the terminator
    if (!consumed && ph_v == PH_ERROR) begin
      done = is_zero;
    end
  end

  // Commit the step, or return to the start after a result
  always_comb begin
    phase_d     = phase_q;
    mag_d       = mag_q;
    open_d      = open_q;
    inner_neg_d = inner_neg_q;
    outer_neg_d = outer_neg_q;
    flags_d     = flags_q;
    w_d         = w_q;
    h_d         = h_q;
    x_d         = x_q;
    y_d         = y_q;
    if (take) begin
      if (done) begin
        phase_d     = PH_START;
        mag_d       = '0;
        open_d      = 1'b0;
        inner_neg_d = 1'b0;
        outer_neg_d = 1'b0;
        flags_d     = '0;
        w_d         = '0;
        h_d         = '0;
        x_d         = '0;
        y_d         = '0;
      end else begin
        phase_d     = ph_v;
        mag_d       = mag_v;
        open_d      = open_v;
        inner_neg_d = inner_v;
        outer_neg_d = outer_v;
        flags_d     = flags_v;
        w_d         = w_v;
        h_d         = h_v;
        x_d         = x_v;
        y_d         = y_v;
      end
    end
  end

  assign out_valid_d = (out_valid_q && !pop_i) || (take && done);

  // Hold parse state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_START;
      mag_q       <= '0;
      open_q      <= 1'b0;
      inner_neg_q <= 1'b0;
      outer_neg_q <= 1'b0;
      flags_q     <= '0;
      w_q         <= '0;
      h_q         <= '0;
      x_q         <= '0;
      y_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      mag_q       <= mag_d;
      open_q      <= open_d;
      inner_neg_q <= inner_neg_d;
      outer_neg_q <= outer_neg_d;
      flags_q     <= flags_d;
      w_q         <= w_d;
      h_q         <= h_d;
      x_q         <= x_d;
      y_q         <= y_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Load the result; an error clears every flag and value
  always_ff @(posedge clk_i) begin
    if (take && done) begin
      if (ph_v == PH_ERROR) begin
        out_flags_q <= '0;
        out_w_q     <= '0;
        out_h_q     <= '0;
        out_x_q     <= '0;
        out_y_q     <= '0;
      end else begin
        out_flags_q <= flags_v;
        out_w_q     <= w_v;
        out_h_q     <= h_v;
        out_x_q     <= x_v;
        out_y_q     <= y_v;
      end
    end
  end

  assign empty_o          = !out_valid_q;
  assign x_present_o      = out_flags_q[FL_X];
  assign y_present_o      = out_flags_q[FL_Y];
  assign width_present_o  = out_flags_q[FL_W];
  assign height_present_o = out_flags_q[FL_H];
  assign x_from_right_o   = out_flags_q[FL_XNEG];
  assign y_from_bottom_o  = out_flags_q[FL_YNEG];
  assign width_value_o    = out_w_q;
  assign height_value_o   = out_h_q;
  assign x_value_o        = out_x_q;
  assign y_value_o        = out_y_q;

  a_stall_only_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tok_valid_i && !tok_pop_o) |-> (is_zero && out_valid_q && !pop_i))
    else $error("parser stalled without a pending result");

  a_terminator_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tok_pop_o && is_zero) |=> !empty_o)
    else $error("terminator did not produce a result");

  a_terminator_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tok_pop_o && is_zero) |=> (phase_q == PH_START && flags_q == '0))
    else $error("parser not back at start after a result");

  a_absent_x_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_flags_q[FL_X]) |-> (out_x_q == '0 && !out_flags_q[FL_XNEG]))
    else $error("x value set without x present");

  a_absent_w_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_flags_q[FL_W]) |-> (out_w_q == '0))
    else $error("width value set without width present");

endmodule

// ===== rtl/geometry_spec_parser.sv =====
// Channel  | Handshake         | Payload
// ---------+-------------------+--------------------------------------------
// input    | push / full       | ch_i (one character, zero ends the string)
// result   | pop / empty       | six flags, width/height/x/y values
//
// One character is taken per cycle while full is low; the parse state machine in
// gsp_back handles any character in one combinational step, multiply-by-ten included.
// A result shows on the ports once its terminator has passed through the token
// queue and then the result register. A four-entry token queue lets input
// keep flowing while a result waits; only a terminator stalls behind an
// unread result. Reset (rst_ni low, asynchronous) empties both queues.
// Top level of the geometry string parser. Instantiates gsp_front and
// gsp_back; depends on gsp_pkg.
module geometry_spec_parser import gsp_pkg::*; #(
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push,
  output logic                         full,
  input  logic [7:0]                   ch_i,
  output logic                         empty,
  input  logic                         pop,
  output logic                         x_present_o,
  output logic                         y_present_o,
  output logic                         width_present_o,
  output logic                         height_present_o,
  output logic                         x_from_right_o,
  output logic                         y_from_bottom_o,
  output logic signed [VALUE_BITS-1:0] width_value_o,
  output logic signed [VALUE_BITS-1:0] height_value_o,
  output logic signed [VALUE_BITS-1:0] x_value_o,
  output logic signed [VALUE_BITS-1:0] y_value_o
);

  logic   tok_valid;
  logic   tok_pop;
  token_t tok;

  // Classify and queue characters
  gsp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .ch_i        (ch_i),
    .tok_valid_o (tok_valid),
    .tok_o       (tok),
    .tok_pop_i   (tok_pop)
  );

  // Parse tokens and hold the result
  gsp_back #(
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .tok_valid_i      (tok_valid),
    .tok_i            (tok),
    .tok_pop_o        (tok_pop),
    .pop_i            (pop),
    .empty_o          (empty),
    .x_present_o      (x_present_o),
    .y_present_o      (y_present_o),
    .width_present_o  (width_present_o),
    .height_present_o (height_present_o),
    .x_from_right_o   (x_from_right_o),
    .y_from_bottom_o  (y_from_bottom_o),
    .width_value_o    (width_value_o),
    .height_value_o   (height_value_o),
    .x_value_o        (x_value_o),
    .y_value_o        (y_value_o)
  );

endmodule
